FILE: rtl/core/gcce_pkg.sv
// Package for the clamp-to-edge 2-D convolution block.
// Holds widths, default parameters, the phase enum and the configuration indexes.
package gcce_pkg;
    localparam int DefMaxWidth  = 2048;
    localparam int DefMaxRadius = 3;
    localparam int HeightLimit  = 2048;
    localparam int CfgWidth     = 12;
    localparam int CfgIdxWidth  = 2;
    localparam logic [CfgIdxWidth-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CfgIdxWidth-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CfgIdxWidth-1:0] CFG_RADIUS = 2'd2;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_TAP,
        PH_DRAIN,
        PH_OUT
    } phase_t;
endpackage

FILE: rtl/core/gcce_if.sv
// Request channel interfaces for the convolution block.
// Depends on nothing; widths are fixed by the field list.
interface gcce_in_if;
    logic               valid;
    logic               ready;
    logic               mode;
    logic [5:0]         coef_index;
    logic signed [17:0] coef_value;
    logic [15:0]        pixel;
    modport source (output valid, mode, coef_index, coef_value, pixel, input ready);
    modport sink   (input valid, mode, coef_index, coef_value, pixel, output ready);
endinterface

interface gcce_out_if;
    logic        valid;
    logic        ready;
    logic [10:0] out_col;
    logic [10:0] out_row;
    logic [15:0] value;
    logic        last;
    modport source (output valid, out_col, out_row, value, last, input ready);
    modport sink   (input valid, out_col, out_row, value, last, output ready);
endinterface

FILE: rtl/core/gcce_core.sv
// Sequencer, line memory and coefficient memory of the convolution block.
// Depends on gcce_pkg; one tap per cycle through a registered multiply-accumulate.
module gcce_core
    import gcce_pkg::*;
#(
    parameter int MAX_WIDTH  = DefMaxWidth,
    parameter int MAX_RADIUS = DefMaxRadius
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [CfgIdxWidth-1:0] cfg_index,
    input  logic [CfgWidth-1:0]    cfg_data,
    gcce_in_if.sink     req,
    gcce_out_if.source  res
);
    localparam int KSpan   = 2 * MAX_RADIUS + 1;
    localparam int KTaps   = KSpan * KSpan;
    localparam int XW      = $clog2(MAX_WIDTH);
    localparam int RowW    = $clog2(KSpan);
    localparam int LineD   = KSpan * MAX_WIDTH;
    localparam int LineAw  = $clog2(LineD);
    localparam int RadW    = $clog2(MAX_RADIUS + 1);
    localparam int TapW    = $clog2(KSpan);
    localparam int CoefAw  = $clog2(KTaps);
    localparam int AccW    = 44;
    localparam int RecipK  = (65536 + KSpan - 1) / KSpan;

    // ring row of a frame row by reciprocal multiplication
    function automatic logic [RowW-1:0] ring_of(input logic [10:0] v);
        logic [27:0] prod;
        logic [10:0] quo;
        logic [10:0] rem;
        prod = 28'(v) * 28'(RecipK);
        quo  = prod[26:16];
        rem  = v - quo * 11'(KSpan);
        return RowW'(rem);
    endfunction

    logic [15:0]        line_mem [LineD];
    logic signed [17:0] coef_mem [KTaps];

    logic [CfgWidth-1:0] width_cfg_reg, height_cfg_reg;
    logic [1:0]          radius_cfg_reg;
    logic [10:0]         col_reg, row_reg;
    phase_t              phase_reg;

    logic [11:0] w_eff, h_eff;
    logic [RadW-1:0] r_eff;
    always_comb
    begin
        w_eff = (width_cfg_reg == '0) ? 12'd1 :
                (width_cfg_reg > 12'(MAX_WIDTH)) ? 12'(MAX_WIDTH) : width_cfg_reg;
        h_eff = (height_cfg_reg == '0) ? 12'd1 :
                (height_cfg_reg > 12'(HeightLimit)) ? 12'(HeightLimit) : height_cfg_reg;
        r_eff = (32'(radius_cfg_reg) > MAX_RADIUS) ? RadW'(MAX_RADIUS)
                                                    : RadW'(radius_cfg_reg);
    end

    // window span of pending outputs
    logic [10:0] xlo_reg, xhi_reg, yhi_reg, ox_reg, oy_reg;
    logic [TapW-1:0] ti_reg, tj_reg;
    logic [AccW-1:0] acc_reg;
    logic            mac_v_reg, mac_last_reg, drain_reg;
    logic signed [34:0] prod_reg;
    logic [15:0] val_reg;
    logic        ovalid_reg, olast_reg;
    logic [10:0] ocol_reg, orow_reg;
    logic [15:0] pix_rd;
    logic signed [17:0] coef_rd;

    wire accept = req.valid && req.ready;
    assign req.ready = (phase_reg == PH_IDLE);

    logic [11:0] c_cur, y_cur;
    always_comb
    begin
        c_cur = (12'(col_reg) >= w_eff) ? w_eff - 12'd1 : 12'(col_reg);
        y_cur = (12'(row_reg) >= h_eff) ? h_eff - 12'd1 : 12'(row_reg);
    end

    logic [11:0] ylo_n, yhi_n, xlo_n, xhi_n;
    logic        any_n;
    always_comb
    begin
        if (y_cur == h_eff - 12'd1)
        begin
            ylo_n = (y_cur >= 12'(r_eff)) ? y_cur - 12'(r_eff) : 12'd0; yhi_n = y_cur;
        end
        else if (y_cur >= 12'(r_eff))
        begin
            ylo_n = y_cur - 12'(r_eff); yhi_n = ylo_n;
        end
        else
        begin
            ylo_n = 12'd1; yhi_n = 12'd0;
        end
        if (c_cur == w_eff - 12'd1)
        begin
            xlo_n = (c_cur >= 12'(r_eff)) ? c_cur - 12'(r_eff) : 12'd0; xhi_n = c_cur;
        end
        else if (c_cur >= 12'(r_eff))
        begin
            xlo_n = c_cur - 12'(r_eff); xhi_n = xlo_n;
        end
        else
        begin
            xlo_n = 12'd1; xhi_n = 12'd0;
        end
        any_n = (ylo_n <= yhi_n) && (xlo_n <= xhi_n);
    end

    // tap address: clamp coordinates
    logic signed [13:0] tx, ty;
    logic [10:0] cx, cy;
    logic [RowW-1:0] ring;
    always_comb
    begin
        tx = $signed({3'b0, ox_reg}) + $signed(14'(ti_reg)) - $signed(14'(r_eff));
        ty = $signed({3'b0, oy_reg}) + $signed(14'(tj_reg)) - $signed(14'(r_eff));
        cx = (tx < 0) ? 11'd0 : (tx >= $signed({2'b0, w_eff})) ? 11'(w_eff - 12'd1) : 11'(tx);
        cy = (ty < 0) ? 11'd0 : (ty >= $signed({2'b0, h_eff})) ? 11'(h_eff - 12'd1) : 11'(ty);
        ring = ring_of(cy);
    end
    wire [LineAw-1:0] tap_addr = LineAw'(ring) * LineAw'(MAX_WIDTH) + LineAw'(cx);
    wire [CoefAw-1:0] coef_addr = CoefAw'(ti_reg) + CoefAw'(tj_reg) * CoefAw'(KSpan);
    wire [LineAw-1:0] wr_addr = LineAw'(ring_of(y_cur[10:0])) * LineAw'(MAX_WIDTH)
                              + LineAw'(c_cur);

    wire tap_last = (ti_reg == TapW'(2 * r_eff)) && (tj_reg == TapW'(2 * r_eff));
    wire pix_last = (ox_reg == xhi_reg) && (oy_reg == yhi_reg);

    always_ff @(posedge clk)
    begin
        if (accept && req.mode)
            line_mem[wr_addr] <= req.pixel;
        if (accept && !req.mode && 32'(req.coef_index) < KTaps)
            coef_mem[CoefAw'(req.coef_index)] <= req.coef_value;
        pix_rd  <= line_mem[tap_addr];
        coef_rd <= coef_mem[coef_addr];
    end

    logic signed [AccW-1:0] sum;
    logic [AccW-1:0] rounded;
    always_comb
    begin
        sum = $signed(acc_reg) + AccW'(32768);
        rounded = sum >>> 16;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg <= 12'd640; height_cfg_reg <= 12'd480; radius_cfg_reg <= 2'd2;
            col_reg <= '0; row_reg <= '0; phase_reg <= PH_IDLE;
            mac_v_reg <= 1'b0; ovalid_reg <= 1'b0;
        end
        else
        begin
            if (res.valid && res.ready)
                ovalid_reg <= 1'b0;
            if (cfg_we && (cfg_index inside {CFG_WIDTH, CFG_HEIGHT, CFG_RADIUS}))
            begin
                case (cfg_index)
                    CFG_WIDTH:  width_cfg_reg  <= cfg_data;
                    CFG_HEIGHT: height_cfg_reg <= cfg_data;
                    CFG_RADIUS: radius_cfg_reg <= cfg_data[1:0];
                    default:    ;
                endcase
                col_reg <= '0; row_reg <= '0;
            end
            mac_v_reg <= 1'b0;
            case (phase_reg)
                PH_IDLE:
                    if (accept && req.mode)
                    begin
                        if (c_cur + 12'd1 >= w_eff)
                        begin
                            col_reg <= '0;
                            row_reg <= (y_cur + 12'd1 >= h_eff) ? 11'd0 : 11'(y_cur + 12'd1);
                        end
                        else
                        begin
                            col_reg <= 11'(c_cur + 12'd1); row_reg <= 11'(y_cur);
                        end
                        if (any_n)
                        begin
                            xlo_reg <= 11'(xlo_n); xhi_reg <= 11'(xhi_n);
                            yhi_reg <= 11'(yhi_n);
                            ox_reg <= 11'(xlo_n); oy_reg <= 11'(ylo_n);
                            ti_reg <= '0; tj_reg <= '0;
                            phase_reg <= PH_TAP;
                        end
                    end
                PH_TAP:
                begin
                    mac_v_reg <= 1'b1;
                    mac_last_reg <= tap_last;
                    if (tap_last)
                        phase_reg <= PH_DRAIN;
                    else if (ti_reg == TapW'(2 * r_eff))
                    begin
                        ti_reg <= '0; tj_reg <= tj_reg + 1'b1;
                    end
                    else
                        ti_reg <= ti_reg + 1'b1;
                end
                PH_DRAIN:
                    if (drain_reg)
                        phase_reg <= PH_OUT;
                PH_OUT:
                    if (!ovalid_reg)
                    begin
                        ovalid_reg <= 1'b1;
                        ocol_reg <= ox_reg; orow_reg <= oy_reg;
                        val_reg <= sum[AccW-1] ? 16'd0 :
                                   (rounded > 44'd65535) ? 16'hFFFF : rounded[15:0];
                        olast_reg <= pix_last;
                        ti_reg <= '0; tj_reg <= '0;
                        if (pix_last)
                            phase_reg <= PH_IDLE;
                        else
                        begin
                            phase_reg <= PH_TAP;
                            if (ox_reg == xhi_reg)
                            begin
                                ox_reg <= xlo_reg; oy_reg <= oy_reg + 1'b1;
                            end
                            else
                                ox_reg <= ox_reg + 1'b1;
                        end
                    end
                default: phase_reg <= PH_IDLE;
            endcase
        end
    end

    // multiply stage then accumulate stage
    logic prod_v_reg, prod_last_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_v_reg <= 1'b0; prod_last_reg <= 1'b0; drain_reg <= 1'b0;
        end
        else
        begin
            prod_v_reg <= mac_v_reg;
            prod_last_reg <= mac_v_reg && mac_last_reg;
            drain_reg <= prod_last_reg;
        end
    end
    always_ff @(posedge clk)
    begin
        if (mac_v_reg)
            prod_reg <= $signed({1'b0, pix_rd}) * coef_rd;
        if (phase_reg == PH_TAP && ti_reg == '0 && tj_reg == '0)
            acc_reg <= '0;
        else if (prod_v_reg && !drain_reg)
            acc_reg <= acc_reg + AccW'(prod_reg);
    end

    assign res.valid   = ovalid_reg;
    assign res.out_col = ocol_reg;
    assign res.out_row = orow_reg;
    assign res.value   = val_reg;
    assign res.last    = olast_reg;

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> phase_reg == PH_IDLE) else $error("ready outside idle");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg && !res.ready |=> ovalid_reg) else $error("result dropped");
    a_tap_bound: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_TAP |-> ti_reg <= TapW'(2 * r_eff)) else $error("tap overrun");
endmodule

FILE: rtl/core/gaussian_convolution_clamp_edge_top.sv
// Top level of the clamp-to-edge 2-D convolution block.
// Depends on gcce_pkg, gcce_if and gcce_core.
//
// Usage: requests enter on the req channel (valid/ready). mode 0 loads one
// coefficient into the coefficient memory; mode 1 delivers one raster pixel,
// which is written into the line memory ring of 2*MAX_RADIUS+1 rows.
// Each pixel request causes 0 to (r+1)^2 results on the res channel, the last
// one flagged by last. Each result is computed one tap a cycle through the line
// memory read port and one registered multiplier, then a two-stage drain. A
// pixel causing no result, like a coefficient load, leaves the sequencer idle.
// Configuration writes (cfg_we, cfg_index, cfg_data) restart the frame; the
// user must make them while idle; the block does not enforce it. Reset sets
// 640x480, radius 2, counters zero; the memories are not cleared. A result
// stalled by the receiver is held in the output register; requests are taken once
// idle, the next result is computed, and ready stays low until the held one drains.
module gaussian_convolution_clamp_edge_top
    import gcce_pkg::*;
#(
    parameter int MAX_WIDTH  = DefMaxWidth,
    parameter int MAX_RADIUS = DefMaxRadius
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [CfgIdxWidth-1:0] cfg_index,
    input  logic [CfgWidth-1:0]    cfg_data,
    gcce_in_if.sink    req,
    gcce_out_if.source res
);
    gcce_core #(.MAX_WIDTH(MAX_WIDTH), .MAX_RADIUS(MAX_RADIUS)) u_core (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .req(req), .res(res)
    );
endmodule

FILE: tb/sv/tb.sv
// Testbench for gaussian_convolution_clamp_edge_top: loads kernels, streams raster frames
// and checks every filtered pixel against an in-bench convolution predictor.
// Depends on gcce_pkg, gcce_if and the block's top level.
`timescale 1ns / 1ps

module tb
    import gcce_pkg::*;
();

    localparam logic MODE_COEF  = 1'b0;
    localparam logic MODE_PIXEL = 1'b1;
    localparam logic [CfgIdxWidth-1:0] CFG_UNUSED = 2'd3;
    localparam int KSPAN      = 2 * DefMaxRadius + 1;
    localparam int KTAPS      = KSPAN * KSPAN;
    localparam int DRAIN_WAIT = 80;
    localparam int STALL_LIMIT = 5000;

    typedef struct packed {
        logic [10:0] col;
        logic [10:0] row;
        logic [15:0] value;
        logic        last;
    } blur_pix_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CfgIdxWidth-1:0] cfg_index;
    logic [CfgWidth-1:0]    cfg_data;

    gcce_in_if  req ();
    gcce_out_if res ();

    gaussian_convolution_clamp_edge_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req.sink),
        .res       (res.source)
    );

    logic signed [17:0] kernel_mem [KTAPS];
    logic [15:0]        ring_mem [KSPAN * DefMaxWidth];
    int unsigned        col_pos;
    int unsigned        row_pos;
    logic [11:0]        width_reg;
    logic [11:0]        height_reg;
    logic [1:0]         radius_reg;

    blur_pix_t   blurred_q [$];
    int unsigned errors;
    int unsigned pixels_sent;
    int unsigned stall_count;
    bit          send_gaps;
    bit          recv_gaps;
    bit          hold_req;
    int unsigned hold_len;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
        if (v < 1)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic int clamp_coord(int v, int n);
        if (v < 0)
            return 0;
        if (v >= n)
            return n - 1;
        return v;
    endfunction

    function automatic logic [15:0] blur_at(int x, int y, int w, int h, int r);
        longint acc;
        int     yy;
        int     xx;
        acc = 0;
        for (int dj = -r; dj <= r; dj++)
        begin
            yy = clamp_coord(y + dj, h);
            for (int di = -r; di <= r; di++)
            begin
                xx = clamp_coord(x + di, w);
                acc += longint'(ring_mem[(yy % KSPAN) * DefMaxWidth + xx])
                       * longint'(kernel_mem[(di + r) + (dj + r) * KSPAN]);
            end
        end
        acc += 32768;
        if (acc < 0)
            return 16'd0;
        acc = acc >>> 16;
        if (acc > 65535)
            return 16'hFFFF;
        return acc[15:0];
    endfunction

    task automatic predict_pixel(logic [15:0] pix);
        int unsigned w;
        int unsigned h;
        int unsigned r;
        int unsigned c;
        int unsigned y;
        int          xlo;
        int          xhi;
        int          ylo;
        int          yhi;
        blur_pix_t   p;
        w = clamp_size(width_reg, DefMaxWidth);
        h = clamp_size(height_reg, HeightLimit);
        r = (radius_reg > DefMaxRadius) ? DefMaxRadius : radius_reg;
        c = (col_pos >= w) ? w - 1 : col_pos;
        y = (row_pos >= h) ? h - 1 : row_pos;
        ring_mem[(y % KSPAN) * DefMaxWidth + c] = pix;
        if (y == h - 1)
        begin
            ylo = (y >= r) ? y - r : 0;
            yhi = y;
        end
        else if (y >= r)
        begin
            ylo = y - r;
            yhi = y - r;
        end
        else
        begin
            ylo = 1;
            yhi = 0;
        end
        if (c == w - 1)
        begin
            xlo = (c >= r) ? c - r : 0;
            xhi = c;
        end
        else if (c >= r)
        begin
            xlo = c - r;
            xhi = c - r;
        end
        else
        begin
            xlo = 1;
            xhi = 0;
        end
        if (ylo <= yhi && xlo <= xhi)
        begin
            for (int yy = ylo; yy <= yhi; yy++)
            begin
                for (int xx = xlo; xx <= xhi; xx++)
                begin
                    p.col   = xx[10:0];
                    p.row   = yy[10:0];
                    p.value = blur_at(xx, yy, w, h, r);
                    p.last  = (yy == yhi) && (xx == xhi);
                    blurred_q.push_back(p);
                end
            end
        end
        if (c + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (y + 1 >= h) ? 0 : y + 1;
        end
        else
        begin
            col_pos = c + 1;
            row_pos = y;
        end
    endtask

    // Caller sits on a rising edge; returns on a rising edge.
    task automatic send_req(logic mode, logic [5:0] idx, logic [17:0] cval, logic [15:0] pix);
        req.valid      <= 1'b1;
        req.mode       <= mode;
        req.coef_index <= idx;
        req.coef_value <= cval;
        req.pixel      <= pix;
        do
            @(posedge clk);
        while (!req.ready);
        if (mode == MODE_COEF)
        begin
            if (idx < KTAPS)
                kernel_mem[idx] = cval;
        end
        else
        begin
            predict_pixel(pix);
            pixels_sent++;
        end
        if (send_gaps && $urandom_range(0, 4) == 0)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
    endtask

    task automatic send_coef(logic [5:0] idx, logic [17:0] cval);
        send_req(MODE_COEF, idx, cval, 16'($urandom));
    endtask

    task automatic send_pixel(logic [15:0] pix);
        send_req(MODE_PIXEL, 6'($urandom), 18'($urandom), pix);
    endtask

    function automatic logic [15:0] rand_pixel();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic wait_drain();
        req.valid <= 1'b0;
        while (blurred_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(logic [CfgIdxWidth-1:0] idx, logic [CfgWidth-1:0] data);
        wait_drain();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_WIDTH:  width_reg  = data;
            CFG_HEIGHT: height_reg = data;
            CFG_RADIUS: radius_reg = data[1:0];
            default: ;
        endcase
        if (idx != CFG_UNUSED)
        begin
            col_pos = 0;
            row_pos = 0;
        end
    endtask

    task automatic set_frame(int unsigned w, int unsigned h, int unsigned r);
        write_reg(CFG_WIDTH, 12'(w));
        write_reg(CFG_HEIGHT, 12'(h));
        write_reg(CFG_RADIUS, {10'($urandom), 2'(r)});
    endtask

    task automatic send_frame(int unsigned n);
        for (int unsigned k = 0; k < n; k++)
            send_pixel(rand_pixel());
    endtask

    task automatic load_kernel();
        for (int i = 0; i < KTAPS; i++)
            send_coef(6'(i), 18'($urandom_range(0, 6000)) - 18'd500);
    endtask

    task automatic test_directed();
        load_kernel();
        send_coef(6'd0, 18'h20000);
        send_coef(6'd1, 18'h1FFFF);
        send_coef(6'd49, 18'h1FFFF);
        send_coef(6'd63, 18'h20000);
        set_frame(3, 2, 1);
        send_pixel(16'h0000);
        send_pixel(16'hFFFF);
        send_pixel(16'hFFFF);
        send_pixel(16'h0000);
        write_reg(CFG_UNUSED, 12'hFFF);
        send_pixel(16'hFFFF);
        send_pixel(16'h8000);
        set_frame(1, 1, 3);
        send_pixel(16'hFFFF);
        send_pixel(16'h0001);
        set_frame(4, 4, 0);
        send_frame(16);
    endtask

    task automatic test_sizes();
        set_frame(4095, 4095, 0);
        send_frame(5);
        set_frame(2048, 2048, 3);
        send_frame(6);
        set_frame(0, 0, 2);
        send_frame(3);
        set_frame(4, 4, 3);
        send_frame(16);
    endtask

    task automatic test_random_frames();
        int unsigned w;
        int unsigned h;
        while (pixels_sent < 330)
        begin
            send_gaps = $urandom_range(0, 2) != 0;
            recv_gaps = $urandom_range(0, 2) != 0;
            w = $urandom_range(1, 10);
            h = $urandom_range(1, 6);
            set_frame(w, h, $urandom_range(0, 3));
            if ($urandom_range(0, 2) == 0)
            begin
                repeat ($urandom_range(1, 4))
                    send_coef(6'($urandom_range(0, 63)), 18'($urandom));
            end
            if ($urandom_range(0, 3) == 0)
                send_frame($urandom_range(1, w * h));
            else
                send_frame(w * h * $urandom_range(1, 2));
        end
        load_kernel();
    endtask

    task automatic test_backpressure();
        send_gaps = 1'b0;
        recv_gaps = 1'b0;
        set_frame(6, 3, 1);
        hold_len = 400;
        hold_req = 1'b1;
        send_frame(18);
        wait_drain();
        send_gaps = 1'b1;
        recv_gaps = 1'b1;
        send_frame(18);
    endtask

    task automatic test_no_idle();
        send_gaps = 1'b0;
        recv_gaps = 1'b0;
        set_frame(5, 4, 2);
        send_frame(20);
    endtask

    initial
    begin
        cfg_we         <= 1'b0;
        cfg_index      <= CFG_WIDTH;
        cfg_data       <= '0;
        req.valid      <= 1'b0;
        req.mode       <= MODE_COEF;
        req.coef_index <= '0;
        req.coef_value <= '0;
        req.pixel      <= '0;
        rst_n          <= 1'b0;
        errors      = 0;
        pixels_sent = 0;
        send_gaps   = 1'b1;
        recv_gaps   = 1'b1;
        hold_req    = 1'b0;
        hold_len    = 0;
        col_pos     = 0;
        row_pos     = 0;
        width_reg   = 12'd640;
        height_reg  = 12'd480;
        radius_reg  = 2'd2;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_sizes();
        test_random_frames();
        test_backpressure();
        test_no_idle();
        wait_drain();
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        res.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                res.ready <= 1'b0;
                repeat (hold_len) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (recv_gaps && $urandom_range(0, 5) == 0)
            begin
                res.ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            res.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        blur_pix_t exp_pix;
        blur_pix_t got_pix;
        if (rst_n)
        begin
            if ((req.valid && req.ready) || (res.valid && res.ready))
                stall_count = 0;
            else
                stall_count++;
            if (stall_count >= STALL_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
            if (res.valid && res.ready)
            begin
                got_pix = {res.out_col, res.out_row, res.value, res.last};
                if (blurred_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %p", $realtime,
                             got_pix);
                    errors++;
                end
                else
                begin
                    exp_pix = blurred_q.pop_front();
                    if (got_pix.col !== exp_pix.col)
                    begin
                        $display("%0t: out_col expected %0d actual %0d", $realtime,
                                 exp_pix.col, got_pix.col);
                        errors++;
                    end
                    if (got_pix.row !== exp_pix.row)
                    begin
                        $display("%0t: out_row expected %0d actual %0d", $realtime,
                                 exp_pix.row, got_pix.row);
                        errors++;
                    end
                    if (got_pix.value !== exp_pix.value)
                    begin
                        $display("%0t: value expected %h actual %h", $realtime,
                                 exp_pix.value, got_pix.value);
                        errors++;
                    end
                    if (got_pix.last !== exp_pix.last)
                    begin
                        $display("%0t: last expected %b actual %b", $realtime,
                                 exp_pix.last, got_pix.last);
                        errors++;
                    end
                end
            end
        end
        else
            stall_count = 0;
    end
endmodule
